>>> design/qcb_pkg.sv
// ----------------------------------------------------------------------------
// qcb_pkg
// Shared types, version tables and GF(256) arithmetic for the QR codeword
// builder (byte mode, level M, versions 1 to 10).
// ----------------------------------------------------------------------------
package qcb_pkg;

    localparam int NCOEF = 26;
    localparam logic [3:0] LONG_COUNT_VER = 4'd10;
    localparam logic [8:0] GF_POLY = 9'h11D;
    localparam logic [3:0] MODE_BYTE = 4'h4;
    localparam logic [7:0] PAD_A = 8'hEC;
    localparam logic [7:0] PAD_B = 8'h11;
    localparam int TEXT_DEPTH = 256;
    localparam int DATA_DEPTH = 216;
    localparam int PAR_DEPTH = 130;

    typedef struct packed {
        logic gen_init;
        logic gen_step;
        logic rem_step;
        logic rem_shift;
    } qcb_rs_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_BUILD_RD,
        ST_BUILD_WR,
        ST_GEN,
        ST_PAR_RD,
        ST_PAR_UP,
        ST_PAR_DUMP,
        ST_SEQ_RD,
        ST_SEQ_CAP,
        ST_EMIT
    } qcb_state_t;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] z;
        z = '0;
        for (int i = 7; i >= 0; i--) begin
            z = {z[7:0], 1'b0};
            if (z[8]) begin
                z = z ^ GF_POLY;
            end
            if (b[i]) begin
                z = z ^ {1'b0, a};
            end
        end
        return z[7:0];
    endfunction

    function automatic logic [8:0] total_cw(input logic [3:0] v);
        case (v)
            4'd1: return 9'd26;
            4'd2: return 9'd44;
            4'd3: return 9'd70;
            4'd4: return 9'd100;
            4'd5: return 9'd134;
            4'd6: return 9'd172;
            4'd7: return 9'd196;
            4'd8: return 9'd242;
            4'd9: return 9'd292;
            4'd10: return 9'd346;
            default: return 9'd0;
        endcase
    endfunction

    function automatic logic [4:0] ec_len(input logic [3:0] v);
        case (v)
            4'd1: return 5'd10;
            4'd2: return 5'd16;
            4'd3: return 5'd26;
            4'd4: return 5'd18;
            4'd5: return 5'd24;
            4'd6: return 5'd16;
            4'd7: return 5'd18;
            4'd8: return 5'd22;
            4'd9: return 5'd22;
            4'd10: return 5'd26;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic [5:0] g1_data(input logic [3:0] v);
        case (v)
            4'd1: return 6'd16;
            4'd2: return 6'd28;
            4'd3: return 6'd44;
            4'd4: return 6'd32;
            4'd5: return 6'd43;
            4'd6: return 6'd27;
            4'd7: return 6'd31;
            4'd8: return 6'd38;
            4'd9: return 6'd36;
            4'd10: return 6'd43;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [2:0] g1_blocks(input logic [3:0] v);
        case (v)
            4'd1, 4'd2, 4'd3: return 3'd1;
            4'd4, 4'd5, 4'd8: return 3'd2;
            4'd6, 4'd7, 4'd10: return 3'd4;
            4'd9: return 3'd3;
            default: return 3'd0;
        endcase
    endfunction

    function automatic logic [2:0] all_blocks(input logic [3:0] v);
        case (v)
            4'd1, 4'd2, 4'd3: return 3'd1;
            4'd4, 4'd5: return 3'd2;
            4'd6, 4'd7, 4'd8: return 3'd4;
            4'd9, 4'd10: return 3'd5;
            default: return 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] data_words(input logic [3:0] v);
        case (v)
            4'd1: return 8'd16;
            4'd2: return 8'd28;
            4'd3: return 8'd44;
            4'd4: return 8'd64;
            4'd5: return 8'd86;
            4'd6: return 8'd108;
            4'd7: return 8'd124;
            4'd8: return 8'd154;
            4'd9: return 8'd182;
            4'd10: return 8'd216;
            default: return 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] byte_cap(input logic [3:0] v);
        case (v)
            4'd1: return 8'd14;
            4'd2: return 8'd26;
            4'd3: return 8'd42;
            4'd4: return 8'd62;
            4'd5: return 8'd84;
            4'd6: return 8'd106;
            4'd7: return 8'd122;
            4'd8: return 8'd152;
            4'd9: return 8'd180;
            4'd10: return 8'd213;
            default: return 8'd0;
        endcase
    endfunction

endpackage

>>> design/qcb_ram.sv
// ----------------------------------------------------------------------------
// qcb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module qcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/qcb_rs_lanes.sv
// ----------------------------------------------------------------------------
// qcb_rs_lanes
// Reed-Solomon generator builder and parity remainder, one GF(256) lane per
// coefficient.
// ----------------------------------------------------------------------------
module qcb_rs_lanes (
    input  logic                aclk,
    input  logic                aresetn,
    input  qcb_pkg::qcb_rs_cmd_t cmd,
    input  logic [4:0]          deg,
    input  logic [7:0]          data_in,
    output logic [7:0]          rem_out
);

    logic [7:0] gen_reg  [qcb_pkg::NCOEF];
    logic [7:0] gen_next [qcb_pkg::NCOEF];
    logic [7:0] rem_reg  [qcb_pkg::NCOEF];
    logic [7:0] rem_next [qcb_pkg::NCOEF];
    logic [7:0] up_g     [qcb_pkg::NCOEF];
    logic [7:0] up_r     [qcb_pkg::NCOEF];
    logic [7:0] root_reg;
    logic [7:0] root_next;
    logic [7:0] fb;

    always_comb begin
        fb = data_in ^ rem_reg[0];
        for (int j = 0; j < qcb_pkg::NCOEF - 1; j++) begin
            up_g[j] = gen_reg[j+1];
            up_r[j] = rem_reg[j+1];
        end
        up_g[qcb_pkg::NCOEF-1] = '0;
        up_r[qcb_pkg::NCOEF-1] = '0;
        root_next = root_reg;
        if (cmd.gen_init) begin
            root_next = 8'd1;
        end else if (cmd.gen_step) begin
            root_next = qcb_pkg::gf_mul(root_reg, 8'h02);
        end
        for (int j = 0; j < qcb_pkg::NCOEF; j++) begin
            gen_next[j] = gen_reg[j];
            rem_next[j] = rem_reg[j];
            if (cmd.gen_init) begin
                gen_next[j] = (5'(j) == deg - 5'd1) ? 8'd1 : 8'd0;
                rem_next[j] = '0;
            end else if (cmd.gen_step) begin
                gen_next[j] = qcb_pkg::gf_mul(gen_reg[j], root_reg) ^ up_g[j];
            end
            if (cmd.rem_step) begin
                rem_next[j] = up_r[j] ^ qcb_pkg::gf_mul(gen_reg[j], fb);
            end else if (cmd.rem_shift) begin
                rem_next[j] = up_r[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        root_reg <= root_next;
        for (int j = 0; j < qcb_pkg::NCOEF; j++) begin
            gen_reg[j] <= gen_next[j];
        end
        if (!aresetn) begin
            for (int j = 0; j < qcb_pkg::NCOEF; j++) begin
                rem_reg[j] <= '0;
            end
        end else begin
            for (int j = 0; j < qcb_pkg::NCOEF; j++) begin
                rem_reg[j] <= rem_next[j];
            end
        end
    end

    assign rem_out = rem_reg[0];

endmodule

>>> design/qr_codeword_builder_unit.sv
// ----------------------------------------------------------------------------
// qr_codeword_builder_unit
// Byte-mode QR level-M codeword builder: stores the message, picks the
// version, builds data codewords, adds Reed-Solomon parity, interleaves.
// ----------------------------------------------------------------------------
//  channel | ports                                       | transaction
//  --------+---------------------------------------------+------------------
//  s_      | s_valid s_ready s_text_byte s_last_byte     | one message byte
//  m_      | m_valid m_ready m_codeword_group            | up to 8 codewords
//          | m_group_bytes m_last_group m_symbol_version |
//          | m_status                                    |
//
//  Message bytes are accepted only while idle. The last byte starts the
//  build, which reads each store through its single read port. Reset
//  clears the control state; no clearing pass. Output stalls hold the
//  sequencer in place.
// ----------------------------------------------------------------------------
module qr_codeword_builder_unit #(
    parameter int MAX_SYMBOL_VERSION = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_codeword_group,
    output logic [3:0]  m_group_bytes,
    output logic        m_last_group,
    output logic [3:0]  m_symbol_version,
    output logic        m_status
);

    localparam logic [3:0] MaxVer = 4'(MAX_SYMBOL_VERSION);
    localparam logic [7:0] TextCap = qcb_pkg::byte_cap(MaxVer);

    qcb_pkg::qcb_state_t state_reg, state_next;

    logic [7:0]  cnt_reg, cnt_next;
    logic        ovf_reg, ovf_next;
    logic [7:0]  len_reg, len_next;
    logic [3:0]  ver_reg, ver_next;
    logic [7:0]  j_reg, j_next;
    logic [3:0]  carry_reg, carry_next;
    logic        pad_reg, pad_next;
    logic [4:0]  pass_reg, pass_next;
    logic [2:0]  blk_reg, blk_next;
    logic [5:0]  idx_reg, idx_next;
    logic [7:0]  off_reg, off_next;
    logic [7:0]  paddr_reg, paddr_next;
    logic        phase_reg, phase_next;
    logic [8:0]  emit_reg, emit_next;
    logic [63:0] grp_reg, grp_next;
    logic [3:0]  gcnt_reg, gcnt_next;

    logic        mv_reg, mv_next;
    logic [63:0] mgrp_reg, mgrp_next;
    logic [3:0]  mbytes_reg, mbytes_next;
    logic        mlast_reg, mlast_next;
    logic [3:0]  mver_reg, mver_next;
    logic        mstat_reg, mstat_next;

    logic        s_fire;
    logic        out_free;
    logic [7:0]  len_in;
    logic        ovf_in;
    logic [3:0]  sel_ver;

    logic [7:0]  dlen;
    logic [4:0]  ecn;
    logic [2:0]  g1b;
    logic [2:0]  nblk;
    logic [5:0]  shortn;
    logic [8:0]  totcw;
    logic [7:0]  hdr;
    logic        long_cnt;
    logic [5:0]  blen;
    logic [7:0]  tpos;
    logic [7:0]  tbyte;
    logic [7:0]  cw;
    logic [7:0]  cap_byte;
    logic [2:0]  pad_sh;
    logic [63:0] grp_aligned;

    logic        txt_we;
    logic [7:0]  txt_waddr, txt_raddr, txt_rdata;
    logic        dat_we;
    logic [7:0]  dat_waddr, dat_wdata, dat_raddr, dat_rdata;
    logic        par_we;
    logic [7:0]  par_waddr, par_raddr, par_rdata;

    qcb_pkg::qcb_rs_cmd_t rs_cmd;
    logic [7:0]  rem_out;

    qcb_ram #(.WIDTH(8), .DEPTH(qcb_pkg::TEXT_DEPTH)) u_text_ram (
        .aclk  (aclk),
        .we    (txt_we),
        .waddr (txt_waddr),
        .wdata (s_text_byte),
        .raddr (txt_raddr),
        .rdata (txt_rdata)
    );

    qcb_ram #(.WIDTH(8), .DEPTH(qcb_pkg::DATA_DEPTH)) u_data_ram (
        .aclk  (aclk),
        .we    (dat_we),
        .waddr (dat_waddr),
        .wdata (dat_wdata),
        .raddr (dat_raddr),
        .rdata (dat_rdata)
    );

    qcb_ram #(.WIDTH(8), .DEPTH(qcb_pkg::PAR_DEPTH)) u_par_ram (
        .aclk  (aclk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (rem_out),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    qcb_rs_lanes u_rs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (rs_cmd),
        .deg     (ecn),
        .data_in (dat_rdata),
        .rem_out (rem_out)
    );

    assign s_ready  = (state_reg == qcb_pkg::ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !mv_reg || m_ready;

    assign len_in = (cnt_reg < TextCap) ? cnt_reg + 8'd1 : cnt_reg;
    assign ovf_in = ovf_reg || (cnt_reg >= TextCap);

    always_comb begin
        sel_ver = MaxVer;
        for (int v = MAX_SYMBOL_VERSION - 1; v >= 1; v--) begin
            if (len_in <= qcb_pkg::byte_cap(4'(v))) begin
                sel_ver = 4'(v);
            end
        end
    end

    assign dlen     = qcb_pkg::data_words(ver_reg);
    assign ecn      = qcb_pkg::ec_len(ver_reg);
    assign g1b      = qcb_pkg::g1_blocks(ver_reg);
    assign nblk     = qcb_pkg::all_blocks(ver_reg);
    assign shortn   = qcb_pkg::g1_data(ver_reg);
    assign totcw    = qcb_pkg::total_cw(ver_reg);
    assign long_cnt = (ver_reg >= qcb_pkg::LONG_COUNT_VER);
    assign hdr      = long_cnt ? 8'd2 : 8'd1;
    assign blen     = shortn + ((blk_reg >= g1b) ? 6'd1 : 6'd0);
    assign tpos     = j_reg - hdr;
    assign tbyte    = (tpos < len_reg) ? txt_rdata : 8'd0;
    assign cap_byte = phase_reg ? par_rdata : dat_rdata;
    assign pad_sh   = 3'(4'd8 - gcnt_reg);
    assign grp_aligned = grp_reg << {pad_sh, 3'b000};

    always_comb begin
        if (j_reg == 8'd0) begin
            cw = long_cnt ? {qcb_pkg::MODE_BYTE, 4'h0} : {qcb_pkg::MODE_BYTE, len_reg[7:4]};
        end else if (long_cnt && j_reg == 8'd1) begin
            cw = {4'h0, len_reg[7:4]};
        end else if (tpos <= len_reg) begin
            cw = {carry_reg, tbyte[7:4]};
        end else begin
            cw = pad_reg ? qcb_pkg::PAD_B : qcb_pkg::PAD_A;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        len_next    = len_reg;
        ver_next    = ver_reg;
        j_next      = j_reg;
        carry_next  = carry_reg;
        pad_next    = pad_reg;
        pass_next   = pass_reg;
        blk_next    = blk_reg;
        idx_next    = idx_reg;
        off_next    = off_reg;
        paddr_next  = paddr_reg;
        phase_next  = phase_reg;
        emit_next   = emit_reg;
        grp_next    = grp_reg;
        gcnt_next   = gcnt_reg;
        mv_next     = mv_reg && !m_ready;
        mgrp_next   = mgrp_reg;
        mbytes_next = mbytes_reg;
        mlast_next  = mlast_reg;
        mver_next   = mver_reg;
        mstat_next  = mstat_reg;

        txt_we    = 1'b0;
        txt_waddr = cnt_reg;
        txt_raddr = tpos;
        dat_we    = 1'b0;
        dat_waddr = j_reg;
        dat_wdata = cw;
        dat_raddr = off_reg + 8'(idx_reg);
        par_we    = 1'b0;
        par_waddr = paddr_reg;
        par_raddr = paddr_reg;
        rs_cmd    = '0;

        unique case (state_reg)
            qcb_pkg::ST_IDLE: begin
                if (s_fire) begin
                    txt_we   = (cnt_reg < TextCap);
                    cnt_next = len_in;
                    ovf_next = ovf_in;
                    if (s_last_byte) begin
                        cnt_next  = '0;
                        ovf_next  = 1'b0;
                        len_next  = len_in;
                        j_next    = '0;
                        carry_next = len_in[3:0];
                        pad_next  = 1'b0;
                        if (ovf_in) begin
                            ver_next   = '0;
                            state_next = qcb_pkg::ST_ERR;
                        end else begin
                            ver_next   = sel_ver;
                            state_next = qcb_pkg::ST_BUILD_RD;
                        end
                    end
                end
            end
            qcb_pkg::ST_ERR: begin
                if (out_free) begin
                    mv_next     = 1'b1;
                    mgrp_next   = '0;
                    mbytes_next = '0;
                    mlast_next  = 1'b1;
                    mver_next   = '0;
                    mstat_next  = 1'b1;
                    state_next  = qcb_pkg::ST_IDLE;
                end
            end
            qcb_pkg::ST_BUILD_RD: begin
                state_next = qcb_pkg::ST_BUILD_WR;
            end
            qcb_pkg::ST_BUILD_WR: begin
                dat_we = 1'b1;
                if (j_reg >= hdr && tpos <= len_reg) begin
                    carry_next = tbyte[3:0];
                end
                if (j_reg >= hdr && tpos > len_reg) begin
                    pad_next = !pad_reg;
                end
                j_next = j_reg + 8'd1;
                state_next = qcb_pkg::ST_BUILD_RD;
                if (j_reg == dlen - 8'd1) begin
                    rs_cmd.gen_init = 1'b1;
                    pass_next  = '0;
                    state_next = qcb_pkg::ST_GEN;
                end
            end
            qcb_pkg::ST_GEN: begin
                rs_cmd.gen_step = 1'b1;
                pass_next = pass_reg + 5'd1;
                if (pass_reg == ecn - 5'd1) begin
                    blk_next   = '0;
                    idx_next   = '0;
                    off_next   = '0;
                    paddr_next = '0;
                    state_next = qcb_pkg::ST_PAR_RD;
                end
            end
            qcb_pkg::ST_PAR_RD: begin
                state_next = qcb_pkg::ST_PAR_UP;
            end
            qcb_pkg::ST_PAR_UP: begin
                rs_cmd.rem_step = 1'b1;
                idx_next   = idx_reg + 6'd1;
                state_next = qcb_pkg::ST_PAR_RD;
                if (idx_reg == blen - 6'd1) begin
                    idx_next   = '0;
                    j_next     = '0;
                    state_next = qcb_pkg::ST_PAR_DUMP;
                end
            end
            qcb_pkg::ST_PAR_DUMP: begin
                par_we = 1'b1;
                rs_cmd.rem_shift = 1'b1;
                paddr_next = paddr_reg + 8'd1;
                j_next     = j_reg + 8'd1;
                if (j_reg == 8'(ecn) - 8'd1) begin
                    off_next   = off_reg + 8'(blen);
                    blk_next   = blk_reg + 3'd1;
                    state_next = qcb_pkg::ST_PAR_RD;
                    if (blk_reg == nblk - 3'd1) begin
                        blk_next   = '0;
                        off_next   = '0;
                        idx_next   = '0;
                        paddr_next = '0;
                        phase_next = 1'b0;
                        emit_next  = '0;
                        gcnt_next  = '0;
                        grp_next   = '0;
                        state_next = qcb_pkg::ST_SEQ_RD;
                    end
                end
            end
            qcb_pkg::ST_SEQ_RD: begin
                if (!phase_reg && idx_reg >= blen) begin
                    // skip the short block's missing column
                    if (blk_reg == nblk - 3'd1) begin
                        blk_next   = '0;
                        off_next   = '0;
                        idx_next   = '0;
                        phase_next = 1'b1;
                        paddr_next = '0;
                    end else begin
                        off_next = off_reg + 8'(blen);
                        blk_next = blk_reg + 3'd1;
                    end
                end else begin
                    state_next = qcb_pkg::ST_SEQ_CAP;
                end
            end
            qcb_pkg::ST_SEQ_CAP: begin
                grp_next  = {grp_reg[55:0], cap_byte};
                gcnt_next = gcnt_reg + 4'd1;
                emit_next = emit_reg + 9'd1;
                if (!phase_reg) begin
                    if (blk_reg == nblk - 3'd1) begin
                        blk_next = '0;
                        off_next = '0;
                        idx_next = idx_reg + 6'd1;
                        if (idx_reg == shortn) begin
                            idx_next   = '0;
                            phase_next = 1'b1;
                            paddr_next = '0;
                        end
                    end else begin
                        off_next = off_reg + 8'(blen);
                        blk_next = blk_reg + 3'd1;
                    end
                end else begin
                    if (blk_reg == nblk - 3'd1) begin
                        blk_next   = '0;
                        idx_next   = idx_reg + 6'd1;
                        paddr_next = 8'(idx_reg) + 8'd1;
                    end else begin
                        blk_next   = blk_reg + 3'd1;
                        paddr_next = paddr_reg + 8'(ecn);
                    end
                end
                if (gcnt_reg == 4'd7 || emit_reg == totcw - 9'd1) begin
                    state_next = qcb_pkg::ST_EMIT;
                end else begin
                    state_next = qcb_pkg::ST_SEQ_RD;
                end
            end
            qcb_pkg::ST_EMIT: begin
                if (out_free) begin
                    mv_next     = 1'b1;
                    mgrp_next   = grp_aligned;
                    mbytes_next = gcnt_reg;
                    mlast_next  = (emit_reg == totcw);
                    mver_next   = ver_reg;
                    mstat_next  = 1'b0;
                    gcnt_next   = '0;
                    grp_next    = '0;
                    state_next  = (emit_reg == totcw) ? qcb_pkg::ST_IDLE
                                                      : qcb_pkg::ST_SEQ_RD;
                end
            end
            default: begin
                state_next = qcb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= qcb_pkg::ST_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            ver_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            ver_reg   <= ver_next;
            mv_reg    <= mv_next;
        end
        len_reg    <= len_next;
        j_reg      <= j_next;
        carry_reg  <= carry_next;
        pad_reg    <= pad_next;
        pass_reg   <= pass_next;
        blk_reg    <= blk_next;
        idx_reg    <= idx_next;
        off_reg    <= off_next;
        paddr_reg  <= paddr_next;
        phase_reg  <= phase_next;
        emit_reg   <= emit_next;
        grp_reg    <= grp_next;
        gcnt_reg   <= gcnt_next;
        mgrp_reg   <= mgrp_next;
        mbytes_reg <= mbytes_next;
        mlast_reg  <= mlast_next;
        mver_reg   <= mver_next;
        mstat_reg  <= mstat_next;
    end

    assign m_valid          = mv_reg;
    assign m_codeword_group = mgrp_reg;
    assign m_group_bytes    = mbytes_reg;
    assign m_last_group     = mlast_reg;
    assign m_symbol_version = mver_reg;
    assign m_status         = mstat_reg;

endmodule

>>> design/qcb_checker.sv
// ----------------------------------------------------------------------------
// qcb_checker
// Port-level checks on the result channel of qr_codeword_builder_unit.
// ----------------------------------------------------------------------------
module qcb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_codeword_group,
    input logic [3:0]  m_group_bytes,
    input logic        m_last_group,
    input logic [3:0]  m_symbol_version,
    input logic        m_status
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_codeword_group)
            && $stable(m_group_bytes) && $stable(m_last_group))
        else $error("result changed while stalled");

    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_last_group && m_group_bytes == 4'd0
            && m_symbol_version == 4'd0 && m_codeword_group == 64'd0)
        else $error("malformed error transaction");

    a_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_status |-> m_group_bytes != 4'd0 && m_group_bytes <= 4'd8
            && m_symbol_version != 4'd0 && m_symbol_version <= 4'd10)
        else $error("bad byte count or version");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_group |-> m_group_bytes == 4'd8)
        else $error("partial group before the last");

endmodule

bind qr_codeword_builder_unit qcb_checker u_qcb_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_codeword_group (m_codeword_group),
    .m_group_bytes    (m_group_bytes),
    .m_last_group     (m_last_group),
    .m_symbol_version (m_symbol_version),
    .m_status         (m_status)
);
